// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the median filter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MF3_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median filter check failed");

// Next-cycle implication, ignored while reset is high.
`define MF3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median filter check failed");

// Next-cycle implication that also holds across reset.
`define MF3_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("median filter check failed");

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared constants, types and the nine-value median function of the median filter.
// Depends on nothing; used by every module of the block but mf3_ram.
`default_nettype none

package mf3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int EFFW_W     = $clog2(MAX_WIDTH + 1);
   localparam int CSUM_W     = EFFW_W + 1;
   localparam int FW_W       = 11;
   localparam int FH_W       = 16;
   localparam int ROW_W      = FH_W + 1;
   localparam int PIX_W      = 32;
   localparam int LUMA_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int FW_RESET   = 640;
   localparam int FH_RESET   = 480;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_sel_type;

   typedef logic [LUMA_W-1:0] luma_type;
   typedef logic [8:0][LUMA_W-1:0] window_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              live;
      logic              emit;
      logic              interior;
      logic              last;
   } tag_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [PIX_W-1:0] pixel;
   } res_type;

   function automatic luma_type lmin(luma_type a, luma_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic luma_type lmax(luma_type a, luma_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic luma_type med3(luma_type a, luma_type b, luma_type c);
      return lmax(lmin(a, b), lmin(lmax(a, b), c));
   endfunction

   // Each row of three is ordered, then the median is the middle of the largest
   // minimum, the median of medians and the smallest maximum.
   function automatic luma_type median9(window_type w);
      luma_type lo [3];
      luma_type md [3];
      luma_type hi [3];
      for (int r = 0; r < 3; r++) begin
         lo[r] = lmin(lmin(w[3*r], w[3*r+1]), w[3*r+2]);
         hi[r] = lmax(lmax(w[3*r], w[3*r+1]), w[3*r+2]);
         md[r] = med3(w[3*r], w[3*r+1], w[3*r+2]);
      end
      return med3(lmax(lmax(lo[0], lo[1]), lo[2]), med3(md[0], md[1], md[2]),
                  lmin(lmin(hi[0], hi[1]), hi[2]));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
// Top level of the 3x3 median filter: stream ports, configuration port, output register.
// Depends on mf3_pkg, mf3_csr, mf3_seq and mf3_window.
//
// The block takes one pixel per clock and gives one result per clock when the
// result side does not stall. On its way to the result register a pixel passes the
// line store read at the accepting edge, the window update and the median; results lag
// the input stream by one row plus one pixel, so after the last pixel of a frame
// the remaining row and pixel are pushed out by flush items (or by further pixels,
// whose values are dropped). A flush that arrives before the whole frame is in is
// taken and has no effect. Ready drops only while the output register holds an
// item that is not taken and the stages behind it are full. The line stores need
// no clearing pass after reset. A write to either frame size register restarts
// the frame and must only be made while no item is in flight.
`default_nettype none

module median_filter_3x3 (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [mf3_pkg::PIX_W-1:0]        req_tdata,   // pixel_in
   input  wire logic                             req_tuser,   // flush
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [mf3_pkg::PIX_W-1:0]        rsp_tdata,   // pixel_out
   output logic                                  rsp_tlast,   // frame_end
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mf3_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mf3_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [mf3_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [mf3_pkg::EFFW_W-1:0] eff_w;
   logic [mf3_pkg::FH_W-1:0]   eff_h;
   logic                       restart, fire, enter, b_free, d_free;
   mf3_pkg::tag_type           tag;
   mf3_pkg::res_type           res;
   logic                       d_valid_ff, d_valid_in;
   logic [mf3_pkg::PIX_W-1:0]  d_pix_ff;
   logic                       d_last_ff;

   mf3_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_w       (eff_w),
      .eff_h       (eff_h),
      .restart     (restart)
   );

   mf3_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .eff_w   (eff_w),
      .eff_h   (eff_h),
      .fire    (fire),
      .flush   (req_tuser),
      .enter   (enter),
      .tag     (tag)
   );

   mf3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .enter    (enter),
      .tag_in   (tag),
      .pix_in   (req_tdata),
      .res_take (d_free),
      .b_free   (b_free),
      .res      (res)
   );

   assign d_free     = ~d_valid_ff | rsp_tready;
   assign req_tready = b_free;
   assign fire       = req_tvalid & req_tready;

   always_comb begin
      d_valid_in = d_valid_ff;
      if (res.valid && d_free) begin
         d_valid_in = 1'b1;
      end else if (rsp_tready) begin
         d_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && d_free) begin
         d_pix_ff  <= res.pixel;
         d_last_ff <= res.last;
      end
   end

   assign rsp_tvalid = d_valid_ff;
   assign rsp_tdata  = d_pix_ff;
   assign rsp_tlast  = d_last_ff;

endmodule

`default_nettype wire

// ===== rtl/mf3_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the line stores of the median filter.
`default_nettype none

module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mf3_csr.sv =====
// Frame size registers behind the APB-style port, with the effective sizes.
// Depends on mf3_pkg.
`default_nettype none

module mf3_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mf3_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [mf3_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [mf3_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output logic      [mf3_pkg::EFFW_W-1:0]        eff_w,
   output logic      [mf3_pkg::FH_W-1:0]          eff_h,
   output logic                                   restart
);

   logic [mf3_pkg::FW_W-1:0] fw_ff, fw_in;
   logic [mf3_pkg::FH_W-1:0] fh_ff, fh_in;
   logic                     wr_strobe;
   mf3_pkg::reg_sel_type     sel;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sel        = mf3_pkg::reg_sel_type'(csr_paddr[2]);
   assign restart    = wr_strobe;

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (wr_strobe) begin
         unique case (sel)
            mf3_pkg::REG_FRAME_WIDTH: begin
               fw_in = csr_pwdata[mf3_pkg::FW_W-1:0];
            end
            mf3_pkg::REG_FRAME_HEIGHT: begin
               fh_in = csr_pwdata[mf3_pkg::FH_W-1:0];
            end
            default: begin
               fw_in = fw_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         mf3_pkg::REG_FRAME_WIDTH: begin
            csr_prdata = (mf3_pkg::CSR_DATA_W)'(fw_ff);
         end
         mf3_pkg::REG_FRAME_HEIGHT: begin
            csr_prdata = (mf3_pkg::CSR_DATA_W)'(fh_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // A width of zero acts as one, and a width beyond the line stores as their depth.
   always_comb begin
      if (fw_ff == '0) begin
         eff_w = (mf3_pkg::EFFW_W)'(1);
      end else if (int'(fw_ff) > mf3_pkg::MAX_WIDTH) begin
         eff_w = (mf3_pkg::EFFW_W)'(mf3_pkg::MAX_WIDTH);
      end else begin
         eff_w = (mf3_pkg::EFFW_W)'(fw_ff);
      end
      eff_h = (fh_ff == '0) ? (mf3_pkg::FH_W)'(1) : fh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= (mf3_pkg::FW_W)'(mf3_pkg::FW_RESET);
         fh_ff <= (mf3_pkg::FH_W)'(mf3_pkg::FH_RESET);
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mf3_seq.sv =====
// Input and output position counters; classifies each accepted item.
// Depends on mf3_pkg.
`default_nettype none

module mf3_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       restart,
   input  wire logic [mf3_pkg::EFFW_W-1:0] eff_w,
   input  wire logic [mf3_pkg::FH_W-1:0]   eff_h,
   input  wire logic                       fire,
   input  wire logic                       flush,
   output logic                            enter,
   output mf3_pkg::tag_type                tag
);

   logic [mf3_pkg::ADDR_W-1:0] col_ff, col_in;
   logic [mf3_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [mf3_pkg::ADDR_W-1:0] ocol_ff, ocol_in;
   logic [mf3_pkg::FH_W-1:0]   orow_ff, orow_in;
   logic                       complete;
   logic [mf3_pkg::EFFW_W-1:0] col_nx;
   logic [mf3_pkg::EFFW_W-1:0] ocol_nx;
   logic [mf3_pkg::CSUM_W-1:0] ocol_sum;
   logic [mf3_pkg::ROW_W-1:0]  orow_sum;

   assign complete = row_ff >= (mf3_pkg::ROW_W)'(eff_h);
   assign enter    = fire & ~(flush & ~complete);
   assign col_nx   = (mf3_pkg::EFFW_W)'(col_ff) + (mf3_pkg::EFFW_W)'(1);
   assign ocol_nx  = (mf3_pkg::EFFW_W)'(ocol_ff) + (mf3_pkg::EFFW_W)'(1);
   assign ocol_sum = (mf3_pkg::CSUM_W)'(ocol_ff) + (mf3_pkg::CSUM_W)'(2);
   assign orow_sum = (mf3_pkg::ROW_W)'(orow_ff) + (mf3_pkg::ROW_W)'(2);

   always_comb begin
      tag.addr     = col_ff;
      tag.live     = ~complete;
      tag.emit     = (row_ff >= (mf3_pkg::ROW_W)'(2)) ||
                     ((row_ff == (mf3_pkg::ROW_W)'(1)) && (col_ff != '0));
      tag.interior = ~complete && (orow_ff != '0) && (ocol_ff != '0) &&
                     (orow_sum <= (mf3_pkg::ROW_W)'(eff_h)) &&
                     (ocol_sum <= (mf3_pkg::CSUM_W)'(eff_w));
      tag.last     = tag.emit && (orow_ff == eff_h - (mf3_pkg::FH_W)'(1)) &&
                     ((mf3_pkg::EFFW_W)'(ocol_ff) == eff_w - (mf3_pkg::EFFW_W)'(1));
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         ocol_in = '0;
         orow_in = '0;
      end else if (enter) begin
         if (col_nx >= eff_w) begin
            col_in = '0;
            row_in = row_ff + (mf3_pkg::ROW_W)'(1);
         end else begin
            col_in = col_nx[mf3_pkg::ADDR_W-1:0];
         end
         if (tag.emit) begin
            if (ocol_nx >= eff_w) begin
               ocol_in = '0;
               orow_in = orow_ff + (mf3_pkg::FH_W)'(1);
            end else begin
               ocol_in = ocol_nx[mf3_pkg::ADDR_W-1:0];
            end
         end
         if (tag.last) begin
            col_in  = '0;
            row_in  = '0;
            ocol_in = '0;
            orow_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mf3_window.sv =====
// Line stores, 3x3 window and median stage: a read stage followed by a median stage.
// Depends on mf3_pkg and mf3_ram.
`default_nettype none

module mf3_window (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      enter,
   input  wire mf3_pkg::tag_type          tag_in,
   input  wire logic [mf3_pkg::PIX_W-1:0] pix_in,
   input  wire logic                      res_take,
   output logic                           b_free,
   output mf3_pkg::res_type               res
);

   logic                        b_valid_ff, b_valid_in;
   mf3_pkg::tag_type            b_tag_ff;
   logic [mf3_pkg::PIX_W-1:0]   b_pix_ff;
   logic                        byp_valid_ff, byp_valid_in;
   logic [mf3_pkg::PIX_W-1:0]   byp_mid_ff;
   mf3_pkg::luma_type           byp_up_ff;
   mf3_pkg::window_type         win_ff, win_in;
   logic [mf3_pkg::PIX_W-1:0]   held_ff;
   logic                        c_valid_ff, c_valid_in;
   logic                        c_emit_ff, c_interior_ff, c_last_ff;
   logic [mf3_pkg::PIX_W-1:0]   c_held_ff;
   logic [mf3_pkg::PIX_W-1:0]   mid_q, mid_rd;
   mf3_pkg::luma_type           up_q, up_rd, med;
   logic                        b_move, c_go, c_free, wr_en;

   assign mid_rd = byp_valid_ff ? byp_mid_ff : mid_q;
   assign up_rd  = byp_valid_ff ? byp_up_ff : up_q;

   assign c_go   = c_valid_ff & (~c_emit_ff | res_take);
   assign c_free = ~c_valid_ff | c_go;
   assign b_move = b_valid_ff & c_free;
   assign b_free = ~b_valid_ff | c_free;
   assign wr_en  = b_move & b_tag_ff.live;

   mf3_ram #(
      .WIDTH (mf3_pkg::LUMA_W),
      .DEPTH (mf3_pkg::MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_tag_ff.addr),
      .wr_data (mid_rd[mf3_pkg::LUMA_W-1:0]),
      .rd_en   (enter),
      .rd_addr (tag_in.addr),
      .rd_data (up_q)
   );

   mf3_ram #(
      .WIDTH (mf3_pkg::PIX_W),
      .DEPTH (mf3_pkg::MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_tag_ff.addr),
      .wr_data (b_pix_ff),
      .rd_en   (enter),
      .rd_addr (tag_in.addr),
      .rd_data (mid_q)
   );

   // A one-column frame reads the column that is being written in the same cycle.
   assign byp_valid_in = wr_en & (b_tag_ff.addr == tag_in.addr);

   always_comb begin
      b_valid_in = b_valid_ff;
      if (enter) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
      c_valid_in = c_valid_ff;
      if (b_move) begin
         c_valid_in = 1'b1;
      end else if (c_go) begin
         c_valid_in = 1'b0;
      end
   end

   always_comb begin
      win_in = win_ff;
      if (wr_en) begin
         for (int r = 0; r < 3; r++) begin
            win_in[3*r]   = win_ff[3*r+1];
            win_in[3*r+1] = win_ff[3*r+2];
         end
         win_in[2] = up_rd;
         win_in[5] = mid_rd[mf3_pkg::LUMA_W-1:0];
         win_in[8] = b_pix_ff[mf3_pkg::LUMA_W-1:0];
      end
   end

   assign med       = mf3_pkg::median9(win_ff);
   assign res.valid = c_valid_ff & c_emit_ff;
   assign res.last  = c_last_ff;
   assign res.pixel = c_interior_ff ? {8'h00, med, med, med} : c_held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         byp_valid_ff <= 1'b0;
         win_ff       <= '0;
         held_ff      <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         win_ff     <= win_in;
         if (enter) begin
            byp_valid_ff <= byp_valid_in;
         end
         if (b_move) begin
            held_ff <= mid_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         b_tag_ff   <= tag_in;
         b_pix_ff   <= pix_in;
         byp_mid_ff <= b_pix_ff;
         byp_up_ff  <= mid_rd[mf3_pkg::LUMA_W-1:0];
      end
      if (b_move) begin
         c_emit_ff     <= b_tag_ff.emit;
         c_interior_ff <= b_tag_ff.interior;
         c_last_ff     <= b_tag_ff.last;
         c_held_ff     <= held_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mf3_checker.sv =====
// Port-level checks of the median filter, bound to its top level.
// Depends on mf3_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mf3_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [mf3_pkg::PIX_W-1:0]      rsp_tdata,
   input wire logic                           rsp_tlast,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic [mf3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [mf3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [mf3_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                           csr_pready
);

   // A result that waits keeps its value.
   `MF3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Reset leaves no result pending.
   `MF3_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

   // With the output register empty the stages behind it can always take an item.
   `MF3_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // A width written is read back from the same address in the next cycle.
   `MF3_ASSERT_NEXT(a_width_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr[2] == 1'b0), (csr_paddr[2] != 1'b0) || (csr_prdata[10:0] == $past(csr_pwdata[10:0])))

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);

`default_nettype wire

// ===== bench/median_filter_3x3_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for median_filter_3x3: predicts every filtered or passed pixel
// and frame end, and compares them in order. Needs mf3_pkg and the block's RTL only.

class median_scoreboard;
   typedef struct {
      logic [31:0] pixel;
      logic        frame_end;
   } out_pixel_type;

   int unsigned width_reg;
   int unsigned height_reg;
   int unsigned eff_w;
   int unsigned eff_h;
   logic [7:0]  upper_luma [mf3_pkg::MAX_WIDTH];
   logic [31:0] middle_row [mf3_pkg::MAX_WIDTH];
   logic [7:0]  win [9];
   logic [31:0] held;
   int unsigned col;
   int unsigned row;
   int unsigned out_col;
   int unsigned out_row;
   int unsigned emitted;
   int unsigned items_taken;
   int unsigned faults;
   out_pixel_type due_pixels [$];

   function new();
      foreach (upper_luma[i]) begin
         upper_luma[i] = '0;
         middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      held = '0;
      items_taken = 0;
      faults = 0;
      width_reg = mf3_pkg::FW_RESET;
      height_reg = mf3_pkg::FH_RESET;
      apply_sizes();
   endfunction

   function void apply_sizes();
      eff_w = (width_reg == 0) ? 1 : width_reg;
      if (eff_w > mf3_pkg::MAX_WIDTH) eff_w = mf3_pkg::MAX_WIDTH;
      eff_h = (height_reg == 0) ? 1 : height_reg;
      restart_frame();
   endfunction

   function void restart_frame();
      col = 0;
      row = 0;
      out_col = 0;
      out_row = 0;
      emitted = 0;
   endfunction

   function void write_register(mf3_pkg::reg_sel_type sel, logic [31:0] value);
      case (sel)
         mf3_pkg::REG_FRAME_WIDTH: width_reg = value[mf3_pkg::FW_W-1:0];
         mf3_pkg::REG_FRAME_HEIGHT: height_reg = value[mf3_pkg::FH_W-1:0];
         default: ;
      endcase
      apply_sizes();
   endfunction

   function logic [7:0] median_of();
      int below;
      int upto;
      for (int i = 0; i < 9; i++) begin
         below = 0;
         upto = 0;
         for (int j = 0; j < 9; j++) begin
            if (win[j] < win[i]) below++;
            if (win[j] <= win[i]) upto++;
         end
         if (below <= 4 && upto >= 5) return win[i];
      end
      return win[0];
   endfunction

   function bit draining();
      return row >= eff_h;
   endfunction

   function int pending();
      return due_pixels.size();
   endfunction

   function void accept_pixel(logic [31:0] pix, logic flush);
      int unsigned c;
      logic [31:0] mid;
      logic [31:0] prev;
      logic [7:0]  m;
      bit          live;
      bit          due;
      out_pixel_type item;
      live = !draining();
      if (live && flush) return;
      items_taken++;
      c = col % mf3_pkg::MAX_WIDTH;
      if (c >= eff_w) c = 0;
      mid = middle_row[c];
      prev = held;
      due = (row >= 2) || (row == 1 && col >= 1);
      if (live) begin
         for (int k = 0; k < 3; k++) begin
            win[3*k] = win[3*k+1];
            win[3*k+1] = win[3*k+2];
         end
         win[2] = upper_luma[c];
         win[5] = mid[7:0];
         win[8] = pix[7:0];
         upper_luma[c] = mid[7:0];
         middle_row[c] = pix;
      end
      held = mid;
      col = c + 1;
      if (col >= eff_w) begin
         col = 0;
         row++;
      end
      if (!due) return;
      item.pixel = prev;
      if (live && out_row >= 1 && out_row + 2 <= eff_h && out_col >= 1 &&
          out_col + 2 <= eff_w) begin
         m = median_of();
         item.pixel = {8'h00, m, m, m};
      end
      emitted++;
      item.frame_end = (emitted >= eff_w * eff_h);
      due_pixels.push_back(item);
      out_col++;
      if (out_col >= eff_w) begin
         out_col = 0;
         out_row++;
      end
      if (item.frame_end) restart_frame();
   endfunction

   task report(string what);
      faults++;
      $display("%0t: %s", $time, what);
   endtask

   task check_pixel(logic [31:0] pix, logic frame_end);
      out_pixel_type item;
      if (due_pixels.size() == 0) begin
         report($sformatf("result %h arrived with none outstanding", pix));
         return;
      end
      item = due_pixels.pop_front();
      if (pix !== item.pixel)
         report($sformatf("pixel %h, predicted %h", pix, item.pixel));
      if (frame_end !== item.frame_end)
         report($sformatf("frame end %b, predicted %b", frame_end, item.frame_end));
   endtask
endclass

module median_filter_3x3_test;

   typedef enum {LUMA_FULL, LUMA_BINARY, LUMA_NARROW} luma_style_type;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 330;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mf3_pkg::PIX_W-1:0]      req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [mf3_pkg::PIX_W-1:0]      rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [mf3_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [mf3_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mf3_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   median_scoreboard board = new();
   int  cycle_count = 0;
   int  burst_left = 0;
   bit  long_hold_due = 1'b0;

   logic [31:0] corner_pixels [9] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_00FF,
                                      32'hFFFF_FF00, 32'h1234_5680, 32'h8000_0001,
                                      32'h7F7F_7F7F, 32'h0000_0080, 32'hA5A5_A5A5};

   median_filter_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel_in
      .req_tuser  (req_tuser),   // flush
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // pixel_out
      .rsp_tlast  (rsp_tlast),   // frame_end
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_pixel(rsp_tdata, rsp_tlast);
   end

   initial begin : result_sink
      int hold_left;
      int phase_left;
      int stall_pct;
      hold_left = 0;
      phase_left = 0;
      stall_pct = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               case ($urandom_range(3))
                  0: stall_pct = 0;
                  1: stall_pct = 10;
                  2: stall_pct = 30;
                  default: stall_pct = 70;
               endcase
               phase_left = $urandom_range(80, 8);
            end
            phase_left--;
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic [31:0] pix, input logic flush);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(32, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= flush;
      do @(posedge clock); while (!req_tready);
      board.accept_pixel(pix, flush);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input mf3_pkg::reg_sel_type sel, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= mf3_pkg::CSR_ADDR_W'(4 * int'(sel));
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_register(sel, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame(input logic [31:0] width, input logic [31:0] height);
      wait_idle();
      write_csr(mf3_pkg::REG_FRAME_WIDTH, width);
      write_csr(mf3_pkg::REG_FRAME_HEIGHT, height);
   endtask

   function automatic logic [31:0] make_pixel(luma_style_type style);
      logic [31:0] p;
      p = $urandom;
      case (style)
         LUMA_BINARY: p[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
         LUMA_NARROW: p[7:0] = 8'($urandom_range(3));
         default: ;
      endcase
      return p;
   endfunction

   // A stop count below the frame size leaves the frame unfinished.
   task automatic run_frame(input luma_style_type style, input int pause_at,
                            input int stop_at);
      int sent;
      sent = 0;
      while (!board.draining()) begin
         if (sent == stop_at) return;
         if (sent == pause_at) begin
            wait_idle();
            pause_at = -1;
         end
         if ($urandom_range(19) == 0) begin
            send_item($urandom, 1'b1);
         end else begin
            send_item(make_pixel(style), 1'b0);
            sent++;
         end
      end
      while (board.draining()) begin
         if ($urandom_range(4) == 0) send_item(make_pixel(style), 1'b0);
         else send_item($urandom, 1'b1);
      end
   endtask

   initial begin : stimulus
      int          w;
      int          h;
      int          frames;
      int          stop_at;
      int          pause_at;
      int unsigned target;
      bit          first;
      bit          paused;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the sizes left by reset no result is due yet; the write restarts the frame.
      for (int i = 0; i < 6; i++) send_item($urandom, 1'b0);
      send_item($urandom, 1'b1);
      set_frame(3, 3);
      foreach (corner_pixels[i]) begin
         send_item(corner_pixels[i], 1'b0);
         if (i == 0) send_item(32'hFFFF_FFFF, 1'b1);
      end
      send_item(32'hDEAD_BEEF, 1'b0);
      while (board.draining()) send_item(32'h0000_0000, 1'b1);

      set_frame(0, 0);
      run_frame(LUMA_FULL, -1, -1);
      set_frame(5, 2);
      run_frame(LUMA_NARROW, -1, -1);
      set_frame(2, 5);
      run_frame(LUMA_FULL, -1, -1);
      set_frame(2047, 3);
      run_frame(LUMA_BINARY, -1, 40);
      set_frame(1024, 2);
      run_frame(LUMA_FULL, -1, 30);
      set_frame(1, 65535);
      run_frame(LUMA_NARROW, -1, 40);
      set_frame(0, 3);
      run_frame(LUMA_FULL, -1, -1);

      target = board.items_taken + RANDOM_ITEMS;
      first = 1'b1;
      paused = 1'b0;
      while (board.items_taken < target) begin
         if (first) begin
            w = 12;
            h = 8;
         end else begin
            case ($urandom_range(9))
               0: w = 3;
               1, 2: w = $urandom_range(40, 13);
               default: w = $urandom_range(12, 1);
            endcase
            h = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
         end
         set_frame({16'($urandom_range(65535)), 5'b0, 11'(w)},
                   {16'($urandom_range(65535)), 16'(h)});
         frames = $urandom_range(3, 1);
         for (int f = 0; f < frames; f++) begin
            if (board.items_taken >= target) break;
            pause_at = (!paused && w * h >= 40) ? w * h / 2 : -1;
            if (pause_at >= 0) paused = 1'b1;
            if (first) long_hold_due = 1'b1;
            first = 1'b0;
            stop_at = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1) : -1;
            run_frame(luma_style_type'($urandom_range(2)), pause_at, stop_at);
            if (stop_at >= 0) break;
         end
      end

      wait_idle();
      if (board.pending() != 0) board.report("results still outstanding at the end");
      if (board.faults == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
